### rtl/glyph_bitmap_pixel_expander_macros.svh
// Assertion macros shared by the checker.
`ifndef GLYPH_BITMAP_PIXEL_EXPANDER_MACROS_SVH
`define GLYPH_BITMAP_PIXEL_EXPANDER_MACROS_SVH

// Same-cycle implication.
`define GBPE_ASSERT_NOW(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("gbpe assertion failed");

// Next-cycle implication.
`define GBPE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("gbpe assertion failed");

`endif

### rtl/gbpe_pkg.sv
package gbpe_pkg;

   localparam logic       OP_START = 1'b0;
   localparam logic       OP_BYTE  = 1'b1;

   localparam logic [1:0] KIND_REG   = 2'd0;
   localparam logic [1:0] KIND_GRAM  = 2'd1;
   localparam logic [1:0] KIND_PIXEL = 2'd2;

   localparam logic [7:0] GRAM_INDEX        = 8'h22;
   localparam logic [7:0] WINDOW_BASE_INDEX = 8'h02;
   localparam logic [4:0] START_LAST_STEP   = 5'd8;

   localparam logic [1:0] CSR_TEXT_COLOR   = 2'd0;
   localparam logic [1:0] CSR_BACK_COLOR   = 2'd1;
   localparam logic [1:0] CSR_GLYPH_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_SYMBOL_SPACE = 2'd3;

   localparam logic [15:0] TEXT_COLOR_RST   = 16'hFFFF;
   localparam logic [15:0] BACK_COLOR_RST   = 16'h0000;
   localparam logic [5:0]  GLYPH_HEIGHT_RST = 6'd16;
   localparam logic [3:0]  SYMBOL_SPACE_RST = 4'd0;
   localparam logic [5:0]  MAX_HEIGHT       = 6'd32;

   typedef struct packed {
      logic       operation;
      logic [9:0] x_pos;
      logic [9:0] y_pos;
      logic [5:0] glyph_width;
      logic [7:0] glyph_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  write_kind;
      logic [7:0]  reg_index;
      logic [15:0] write_value;
      logic        last;
   } rsp_type;

   // One queued job for the back end.
   typedef struct packed {
      logic       is_start;
      logic [9:0] sx;
      logic [9:0] ex;
      logic [9:0] sy;
      logic [9:0] ey;
      logic [7:0] bits;
      logic [3:0] npix;
      logic [3:0] nspace;
   } desc_type;

   typedef struct packed {
      logic     push;
      desc_type desc;
   } enq_type;

   typedef struct packed {
      logic     valid;
      desc_type desc;
   } deq_type;

endpackage

### rtl/gbpe_front.sv
module gbpe_front #(
   parameter int PANEL_WIDTH     = 240,
   parameter int PANEL_HEIGHT    = 320,
   parameter int MAX_GLYPH_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gbpe_pkg::req_type req_item,
   input  logic [5:0]       glyph_height,
   input  logic [3:0]       symbol_space,
   input  logic             queue_full,
   output gbpe_pkg::enq_type enq
);

   logic [5:0] rbp_ff, rbp_in;
   logic [5:0] row_ff, row_in;
   logic [5:0] width_ff, width_in;
   logic       active_ff, active_in;

   logic        accept;
   logic [5:0]  w_eff, h_eff;
   logic [11:0] ex_wide, ey_wide;
   logic        off_panel;
   logic [5:0]  remain, rbp_sum, row_next;
   logic [3:0]  npix;
   logic        row_done;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      if (req_item.glyph_width == 6'd0) begin
         w_eff = 6'd1;
      end else if (req_item.glyph_width > 6'(MAX_GLYPH_WIDTH)) begin
         w_eff = 6'(MAX_GLYPH_WIDTH);
      end else begin
         w_eff = req_item.glyph_width;
      end
      if (glyph_height == 6'd0) begin
         h_eff = 6'd1;
      end else if (glyph_height > gbpe_pkg::MAX_HEIGHT) begin
         h_eff = gbpe_pkg::MAX_HEIGHT;
      end else begin
         h_eff = glyph_height;
      end
   end

   assign ex_wide = 12'(req_item.x_pos) + 12'(w_eff) + 12'(symbol_space) - 12'd1;
   assign ey_wide = 12'(req_item.y_pos) + 12'(h_eff) - 12'd1;
   assign off_panel = (12'(req_item.x_pos) > 12'(PANEL_WIDTH - 1))
                   || (ex_wide > 12'(PANEL_WIDTH - 1))
                   || (12'(req_item.y_pos) > 12'(PANEL_HEIGHT - 1))
                   || (ey_wide > 12'(PANEL_HEIGHT - 1));

   assign remain   = width_ff - rbp_ff;
   assign npix     = (remain > 6'd8) ? 4'd8 : remain[3:0];
   assign rbp_sum  = rbp_ff + 6'(npix);
   assign row_done = rbp_sum >= width_ff;
   assign row_next = row_ff + 6'd1;

   always_comb begin
      enq.push        = 1'b0;
      enq.desc        = '0;
      enq.desc.bits   = req_item.glyph_byte;
      enq.desc.npix   = npix;
      enq.desc.nspace = row_done ? symbol_space : 4'd0;
      rbp_in          = rbp_ff;
      row_in          = row_ff;
      width_in        = width_ff;
      active_in       = active_ff;
      if (accept) begin
         if (req_item.operation == gbpe_pkg::OP_START) begin
            enq.push          = 1'b1;
            enq.desc.is_start = 1'b1;
            if (!off_panel) begin
               enq.desc.sx = req_item.x_pos;
               enq.desc.ex = ex_wide[9:0];
               enq.desc.sy = req_item.y_pos;
               enq.desc.ey = ey_wide[9:0];
            end
            width_in  = w_eff;
            rbp_in    = 6'd0;
            row_in    = 6'd0;
            active_in = 1'b1;
         end else if (active_ff) begin
            enq.push = 1'b1;
            if (row_done) begin
               rbp_in = 6'd0;
               if (row_next >= h_eff) begin
                  row_in    = 6'd0;
                  active_in = 1'b0;
               end else begin
                  row_in = row_next;
               end
            end else begin
               rbp_in = rbp_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rbp_ff    <= 6'd0;
         row_ff    <= 6'd0;
         width_ff  <= 6'd1;
         active_ff <= 1'b0;
      end else begin
         rbp_ff    <= rbp_in;
         row_ff    <= row_in;
         width_ff  <= width_in;
         active_ff <= active_in;
      end
   end

endmodule

### rtl/gbpe_queue.sv
module gbpe_queue (
   input  logic              clock,
   input  logic              reset,
   input  gbpe_pkg::enq_type enq,
   output logic              full,
   output gbpe_pkg::deq_type deq,
   input  logic              pop
);

   gbpe_pkg::desc_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign full      = count_ff == 2'd2;
   assign deq.valid = count_ff != 2'd0;
   assign deq.desc  = mem_ff[rd_ptr_ff];
   assign do_pop    = pop && deq.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ enq.push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(enq.push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (enq.push) begin
         mem_ff[wr_ptr_ff] <= enq.desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/gbpe_back.sv
module gbpe_back (
   input  logic              clock,
   input  logic              reset,
   input  gbpe_pkg::deq_type deq,
   output logic              pop,
   input  logic [15:0]       text_color,
   input  logic [15:0]       back_color,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbpe_pkg::rsp_type rsp_item
);

   logic [4:0]        step_ff, step_in;
   logic              valid_ff, valid_in;
   gbpe_pkg::rsp_type item_ff, item_in;

   logic       load;
   logic [4:0] total;
   logic [9:0] coord;
   logic       is_last;

   assign load = deq.valid && (!valid_ff || !rsp_stall);

   always_comb begin
      case (step_ff[2:1])
         2'd0:    coord = deq.desc.sx;
         2'd1:    coord = deq.desc.ex;
         2'd2:    coord = deq.desc.sy;
         default: coord = deq.desc.ey;
      endcase
   end

   assign total   = 5'(deq.desc.npix) + 5'(deq.desc.nspace);
   assign is_last = deq.desc.is_start ? (step_ff == gbpe_pkg::START_LAST_STEP)
                                      : (step_ff == total - 5'd1);

   always_comb begin
      item_in      = '0;
      item_in.last = is_last;
      if (deq.desc.is_start) begin
         if (step_ff == gbpe_pkg::START_LAST_STEP) begin
            item_in.write_kind = gbpe_pkg::KIND_GRAM;
            item_in.reg_index  = gbpe_pkg::GRAM_INDEX;
         end else begin
            item_in.write_kind  = gbpe_pkg::KIND_REG;
            item_in.reg_index   = gbpe_pkg::WINDOW_BASE_INDEX + 8'(step_ff);
            item_in.write_value = step_ff[0] ? 16'(coord[7:0]) : 16'(coord[9:8]);
         end
      end else begin
         item_in.write_kind = gbpe_pkg::KIND_PIXEL;
         if (step_ff < 5'(deq.desc.npix) && deq.desc.bits[step_ff[2:0]]) begin
            item_in.write_value = text_color;
         end else begin
            item_in.write_value = back_color;
         end
      end
   end

   assign pop = load && is_last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
         step_in  = is_last ? 5'd0 : step_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= 5'd0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

### rtl/glyph_bitmap_pixel_expander.sv
// Glyph bitmap pixel expander. A start item yields nine results (eight window
// register writes, then the GRAM select); a glyph byte item yields its row's
// remaining pixels (up to eight) plus, at row end, the spacing pixels, so one
// to 23 results while a glyph is open and none otherwise. The output sequencer
// issues one result per cycle while the output is not stalled. The front end
// takes one item per cycle while its two-entry job queue has room, and keeps
// taking items while a result waits on a stalled output.
module glyph_bitmap_pixel_expander #(
   parameter int PANEL_WIDTH     = 240,
   parameter int PANEL_HEIGHT    = 320,
   parameter int MAX_GLYPH_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbpe_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbpe_pkg::rsp_type rsp_item,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   logic [15:0] text_color_ff, back_color_ff;
   logic [5:0]  glyph_height_ff;
   logic [3:0]  symbol_space_ff;

   gbpe_pkg::enq_type enq;
   gbpe_pkg::deq_type deq;
   logic              queue_full;
   logic              pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff   <= gbpe_pkg::TEXT_COLOR_RST;
         back_color_ff   <= gbpe_pkg::BACK_COLOR_RST;
         glyph_height_ff <= gbpe_pkg::GLYPH_HEIGHT_RST;
         symbol_space_ff <= gbpe_pkg::SYMBOL_SPACE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            gbpe_pkg::CSR_TEXT_COLOR:   text_color_ff   <= csr_wdata;
            gbpe_pkg::CSR_BACK_COLOR:   back_color_ff   <= csr_wdata;
            gbpe_pkg::CSR_GLYPH_HEIGHT: glyph_height_ff <= csr_wdata[5:0];
            gbpe_pkg::CSR_SYMBOL_SPACE: symbol_space_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   gbpe_front #(
      .PANEL_WIDTH    (PANEL_WIDTH),
      .PANEL_HEIGHT   (PANEL_HEIGHT),
      .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .glyph_height(glyph_height_ff),
      .symbol_space(symbol_space_ff),
      .queue_full  (queue_full),
      .enq         (enq)
   );

   gbpe_queue u_queue (
      .clock(clock),
      .reset(reset),
      .enq  (enq),
      .full (queue_full),
      .deq  (deq),
      .pop  (pop)
   );

   gbpe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .deq       (deq),
      .pop       (pop),
      .text_color(text_color_ff),
      .back_color(back_color_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

### rtl/gbpe_checker.sv
`include "glyph_bitmap_pixel_expander_macros.svh"

module gbpe_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input gbpe_pkg::rsp_type rsp_item
);

   `GBPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `GBPE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_item))
   `GBPE_ASSERT_NOW(a_gram_ends_start, clock, reset, rsp_valid && rsp_item.write_kind == gbpe_pkg::KIND_GRAM, rsp_item.last && rsp_item.reg_index == gbpe_pkg::GRAM_INDEX && rsp_item.write_value == 16'd0)
   `GBPE_ASSERT_NOW(a_high_byte_narrow, clock, reset, rsp_valid && rsp_item.write_kind == gbpe_pkg::KIND_REG && !rsp_item.reg_index[0], rsp_item.write_value[15:2] == 14'd0 && !rsp_item.last)

endmodule

bind glyph_bitmap_pixel_expander gbpe_checker u_gbpe_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_item (rsp_item)
);

### sim/glyph_bitmap_pixel_expander_tb.sv
module glyph_bitmap_pixel_expander_tb;

   localparam int PANEL_W       = 240;
   localparam int PANEL_H       = 320;
   localparam int GLYPH_W_MAX   = 32;
   localparam int SETTLE_CYCLES = 40;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_ITEMS  = 370;

   class panel_write_checker;
      logic [15:0]       text_color;
      logic [15:0]       back_color;
      logic [5:0]        glyph_height;
      logic [3:0]        symbol_space;
      int                row_pos;
      logic [5:0]        row_num;
      int                cur_width;
      bit                glyph_open;
      gbpe_pkg::rsp_type expected_writes[$];
      int                error_count;

      function new();
         text_color   = gbpe_pkg::TEXT_COLOR_RST;
         back_color   = gbpe_pkg::BACK_COLOR_RST;
         glyph_height = gbpe_pkg::GLYPH_HEIGHT_RST;
         symbol_space = gbpe_pkg::SYMBOL_SPACE_RST;
         row_pos      = 0;
         row_num      = '0;
         cur_width    = 1;
         glyph_open   = 1'b0;
         error_count  = 0;
      endfunction

      function void write_register(logic [1:0] idx, logic [15:0] value);
         case (idx)
            gbpe_pkg::CSR_TEXT_COLOR:   text_color   = value;
            gbpe_pkg::CSR_BACK_COLOR:   back_color   = value;
            gbpe_pkg::CSR_GLYPH_HEIGHT: glyph_height = value[5:0];
            gbpe_pkg::CSR_SYMBOL_SPACE: symbol_space = value[3:0];
            default: ;
         endcase
      endfunction

      function int glyph_rows();
         int h;
         h = glyph_height;
         if (h == 0) h = 1;
         if (h > 32) h = 32;
         return h;
      endfunction

      function int pending();
         return expected_writes.size();
      endfunction

      function void push_write(logic [1:0] kind, logic [7:0] idx, logic [15:0] value);
         gbpe_pkg::rsp_type w;
         w.write_kind  = kind;
         w.reg_index   = idx;
         w.write_value = value;
         w.last        = 1'b0;
         expected_writes.push_back(w);
      endfunction

      // Returns the number of writes this item causes.
      function int note_item(gbpe_pkg::req_type r);
         int unsigned coord[4];
         int          width;
         int          npix;
         int          first;
         int          k;
         first = expected_writes.size();
         if (r.operation == gbpe_pkg::OP_START) begin
            width = r.glyph_width;
            if (width == 0) width = 1;
            if (width > GLYPH_W_MAX) width = GLYPH_W_MAX;
            coord[0] = r.x_pos;
            coord[1] = r.x_pos + width + symbol_space - 1;
            coord[2] = r.y_pos;
            coord[3] = r.y_pos + glyph_rows() - 1;
            if (coord[0] > PANEL_W - 1 || coord[1] > PANEL_W - 1 ||
                coord[2] > PANEL_H - 1 || coord[3] > PANEL_H - 1) begin
               coord = '{0, 0, 0, 0};
            end
            for (k = 0; k < 8; k++) begin
               push_write(gbpe_pkg::KIND_REG, gbpe_pkg::WINDOW_BASE_INDEX + 8'(k),
                          (k % 2 == 0) ? 16'((coord[k / 2] >> 8) & 'hFF)
                                       : 16'(coord[k / 2] & 'hFF));
            end
            push_write(gbpe_pkg::KIND_GRAM, gbpe_pkg::GRAM_INDEX, 16'h0000);
            cur_width  = width;
            row_pos    = 0;
            row_num    = '0;
            glyph_open = 1'b1;
         end else if (glyph_open) begin
            npix = (cur_width > row_pos) ? cur_width - row_pos : 0;
            if (npix > 8) npix = 8;
            for (k = 0; k < npix; k++) begin
               push_write(gbpe_pkg::KIND_PIXEL, 8'h00,
                          r.glyph_byte[k] ? text_color : back_color);
            end
            row_pos += npix;
            if (row_pos >= cur_width) begin
               for (k = 0; k < symbol_space; k++) begin
                  push_write(gbpe_pkg::KIND_PIXEL, 8'h00, back_color);
               end
               row_pos = 0;
               row_num = row_num + 6'd1;
               if (row_num >= glyph_rows()) begin
                  row_num    = '0;
                  glyph_open = 1'b0;
               end
            end
         end
         if (expected_writes.size() > first) begin
            expected_writes[expected_writes.size() - 1].last = 1'b1;
         end
         return expected_writes.size() - first;
      endfunction

      function void check_write(gbpe_pkg::rsp_type got);
         gbpe_pkg::rsp_type want;
         if (expected_writes.size() == 0) begin
            $display("%0t: unexpected write, expected none, got %h", $time, got);
            error_count++;
            return;
         end
         want = expected_writes.pop_front();
         if (got.write_kind != want.write_kind) begin
            $display("%0t: write_kind expected %0d got %0d",
                     $time, want.write_kind, got.write_kind);
            error_count++;
         end
         if (got.reg_index != want.reg_index) begin
            $display("%0t: reg_index expected %h got %h",
                     $time, want.reg_index, got.reg_index);
            error_count++;
         end
         if (got.write_value != want.write_value) begin
            $display("%0t: write_value expected %h got %h",
                     $time, want.write_value, got.write_value);
            error_count++;
         end
         if (got.last != want.last) begin
            $display("%0t: last expected %b got %b", $time, want.last, got.last);
            error_count++;
         end
      endfunction
   endclass

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_stall;
   gbpe_pkg::req_type req_item     = '0;
   logic              rsp_valid;
   logic              rsp_stall    = 1'b0;
   gbpe_pkg::rsp_type rsp_item;
   logic              csr_write_en = 1'b0;
   logic [1:0]        csr_index    = '0;
   logic [15:0]       csr_wdata    = '0;

   panel_write_checker sb;
   bit          steady = 1'b0;
   int          live_items;
   int          stall_left = 0;
   int          idle_cycles;
   logic [15:0] cur_text, cur_back;
   logic [5:0]  cur_height;
   logic [3:0]  cur_space;

   glyph_bitmap_pixel_expander dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function int rand_gap();
      int pick;
      if (steady) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function gbpe_pkg::req_type make_item(logic op, int x, int y, int w, int b);
      gbpe_pkg::req_type r;
      r.operation   = op;
      r.x_pos       = 10'(x);
      r.y_pos       = 10'(y);
      r.glyph_width = 6'(w);
      r.glyph_byte  = 8'(b);
      return r;
   endfunction

   function gbpe_pkg::req_type random_byte();
      logic [63:0]       raw;
      gbpe_pkg::req_type r;
      raw = {$urandom, $urandom};
      r = gbpe_pkg::req_type'(raw[$bits(gbpe_pkg::req_type)-1:0]);
      r.operation = gbpe_pkg::OP_BYTE;
      return r;
   endfunction

   function gbpe_pkg::req_type random_start();
      gbpe_pkg::req_type r;
      r = random_byte();
      r.operation = gbpe_pkg::OP_START;
      if ($urandom_range(0, 3) != 0) begin
         r.x_pos       = 10'($urandom_range(0, 200));
         r.y_pos       = 10'($urandom_range(0, 280));
         r.glyph_width = 6'($urandom_range(1, 16));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_write(rsp_item);
         if (stall_left == 0) stall_left = rand_gap();
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("glyph_bitmap_pixel_expander_tb: done, errors");
      $finish;
   end

   task send_item(gbpe_pkg::req_type r);
      int gap;
      req_item  <= r;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_item(r));
      live_items++;
      gap = rand_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Called only when the block is idle.
   task set_registers(logic [15:0] text, logic [15:0] back, logic [5:0] height,
                      logic [3:0] space);
      logic [15:0] vals[4];
      int          k;
      vals = '{text, back, {10'd0, height}, {12'd0, space}};
      for (k = 0; k < 4; k++) begin
         csr_write_en <= 1'b1;
         csr_index    <= 2'(k);
         csr_wdata    <= vals[k];
         @(posedge clock);
         sb.write_register(2'(k), vals[k]);
      end
      csr_write_en <= 1'b0;
      cur_text   = text;
      cur_back   = back;
      cur_height = height;
      cur_space  = space;
   endtask

   task send_glyph(bit complete);
      gbpe_pkg::req_type r;
      int                w;
      int                nbytes;
      r = random_start();
      w = r.glyph_width;
      if (w == 0) w = 1;
      if (w > GLYPH_W_MAX) w = GLYPH_W_MAX;
      nbytes = ((w + 7) / 8) * sb.glyph_rows();
      if (!complete) nbytes = $urandom_range(0, nbytes - 1);
      if (nbytes > RANDOM_ITEMS - live_items - 1) nbytes = RANDOM_ITEMS - live_items - 1;
      send_item(r);
      repeat (nbytes) send_item(random_byte());
   endtask

   initial begin
      int phase;
      int budget;
      int pick;
      sb = new();
      live_items = 0;
      cur_text   = gbpe_pkg::TEXT_COLOR_RST;
      cur_back   = gbpe_pkg::BACK_COLOR_RST;
      cur_height = gbpe_pkg::GLYPH_HEIGHT_RST;
      cur_space  = gbpe_pkg::SYMBOL_SPACE_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset register values; byte with nothing open, then abandon mid-glyph
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hFF));
      send_item(make_item(gbpe_pkg::OP_START, 0, 0, 8, 0));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hFF));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h00));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hA5));
      // off panel, width above max
      send_item(make_item(gbpe_pkg::OP_START, 1023, 1023, 63, 0));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h55));
      drain();

      // height zero, widest spacing, window on the panel edge
      set_registers(16'h0000, 16'hFFFF, 6'd0, 4'd15);
      send_item(make_item(gbpe_pkg::OP_START, 224, 319, 0, 0));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h01));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hFF));
      send_item(make_item(gbpe_pkg::OP_START, 225, 0, 1, 0));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hFE));
      drain();

      // height above max, then lowered while the glyph is open
      set_registers(16'h1234, 16'hABCD, 6'd63, 4'd0);
      send_item(make_item(gbpe_pkg::OP_START, 208, 288, 9, 0));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hFF));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h01));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h00));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hFF));
      drain();
      set_registers(cur_text, cur_back, 6'd1, cur_space);
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h0F));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'hF0));
      send_item(make_item(gbpe_pkg::OP_BYTE, 0, 0, 0, 8'h33));
      send_item(make_item(gbpe_pkg::OP_START, 208, 319, 32, 0));
      drain();

      phase = 0;
      while (live_items < RANDOM_ITEMS) begin
         drain();
         steady = (phase % 3 == 2);
         case (phase)
            0:       set_registers(16'hFFFF, 16'h0000, 6'd32, 4'd0);
            1:       set_registers(16'h0000, 16'hFFFF, 6'd1, 4'd15);
            default: set_registers(16'($urandom), 16'($urandom),
                                   ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                               : 6'($urandom_range(1, 4)),
                                   4'($urandom_range(0, 15)));
         endcase
         budget = live_items + 45;
         while (live_items < budget && live_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) send_glyph(1'b1);
            else if (pick < 85) send_glyph(1'b0);
            else if (pick < 95) send_item($urandom_range(0, 1) ? random_byte()
                                                              : random_start());
            else drain();
         end
         phase++;
      end
      steady = 1'b0;
      drain();

      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("glyph_bitmap_pixel_expander_tb: done, clean");
      end else begin
         $display("glyph_bitmap_pixel_expander_tb: done, errors");
      end
      $finish;
   end

endmodule
